// ----- hw/rtl/first_fit_range_allocator_unit_macros.svh -----
// assertion macros for the first-fit range allocator
// expects signals clk and arst_n in the scope where a macro is used
`ifndef FIRST_FIT_RANGE_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FFRA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFRA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ffra_pkg.sv -----
// shared types and constants of the first-fit range allocator
// no dependencies
package ffra_pkg;

	localparam int PAGE_BITS     = 36;
	localparam int MAX_AREAS_DEF = 16;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [PAGE_BITS:0]   page_ext_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_WINDOW_START = 1'b0,
		CFG_WINDOW_END   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		kind_t kind;
		page_t request_size;
		logic  owner_flag;
		page_t free_start;
	} in_word_t;

	typedef struct packed {
		status_t status;
		page_t   granted_start;
		page_t   freed_size;
		logic    freed_owns;
	} out_word_t;

	typedef struct packed {
		page_t start;
		page_t size;
		logic  owns;
	} entry_t;

	// what the selected cell offers to the gather stage
	typedef struct packed {
		page_ext_t cand;
		page_t     size;
		logic      owns;
	} pick_t;

	// request and commit control broadcast to every cell
	typedef struct packed {
		kind_t kind;
		page_t size;
		logic  owns;
		page_t fstart;
		page_t cand;
		logic  ins;
		logic  del;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/ffra_cell.sv -----
// one slot of the sorted range table: holds an entry, tests it against the request
// and shifts with its neighbors on insert or remove; uses ffra_pkg
module ffra_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ffra_pkg::cell_ctl_t ctl,
	input  logic                valid,
	input  ffra_pkg::page_ext_t prev_end,
	output ffra_pkg::page_ext_t end_out,
	input  ffra_pkg::entry_t    left_entry,
	input  ffra_pkg::entry_t    right_entry,
	output ffra_pkg::entry_t    entry,
	input  logic                before_in,
	output logic                before_out,
	output logic                slot,
	output ffra_pkg::pick_t     pick
);
	import ffra_pkg::*;

	entry_t                 entry_q;
	logic                   hit_q;
	logic                   at_q;
	logic                   after_q;
	logic [PAGE_BITS+1:0]   need;
	logic                   fit;
	logic                   match;
	logic                   hit;

	assign end_out = {1'b0, entry_q.start} + {1'b0, entry_q.size};
	assign need    = {1'b0, prev_end} + {2'b0, ctl.size};
	assign fit     = need <= {2'b0, entry_q.start};
	assign match   = entry_q.start == ctl.fstart;

	// an empty slot always takes an allocation: it is the append position
	always_comb begin
		case (ctl.kind)
			KIND_ALLOC: hit = !valid || fit;
			KIND_FREE:  hit = valid && match;
			default:    hit = 1'b0;
		endcase
	end

	assign before_out = before_in | hit_q;
	assign slot       = at_q;
	assign entry      = entry_q;

	always_comb begin
		pick = '0;
		if (at_q) begin
			pick.cand = prev_end;
			pick.size = entry_q.size;
			pick.owns = entry_q.owns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			at_q    <= 1'b0;
			after_q <= 1'b0;
		end else begin
			hit_q   <= hit;
			at_q    <= hit_q & ~before_in;
			after_q <= before_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && at_q) begin
			entry_q.start <= ctl.cand;
			entry_q.size  <= ctl.size;
			entry_q.owns  <= ctl.owns;
		end else if (ctl.ins && after_q) begin
			entry_q <= left_entry;
		end else if (ctl.del && (at_q || after_q)) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- hw/rtl/first_fit_range_allocator_unit.sv -----
// top level of the first-fit range allocator: control sequencer, window registers,
// output register and the row of ffra_cell slots; uses ffra_pkg and the macros header
`include "first_fit_range_allocator_unit_macros.svh"

// Each word passes these steps from acceptance to a valid result in the output
// register, whatever the table depth: every slot compares its entry with the
// request, the first-match priority chain runs along the row, the chosen slot's
// data is gathered, the result is decided and the table shifted, and the result
// is moved out. in_stall stays high from acceptance until the result is in the
// output register, so a new word is not taken before the last one is through,
// and out_stall holding an earlier result there delays the next word further.
// Allocation grants the first gap from window_start that fits; free removes the
// first entry whose start matches. Window registers may be written only while no
// word is in flight.
module first_fit_range_allocator_unit #(
	parameter int MAX_AREAS = ffra_pkg::MAX_AREAS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [0:0]         cfg_index,
	input  ffra_pkg::page_t    cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  ffra_pkg::in_word_t in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output ffra_pkg::out_word_t out_word
);
	import ffra_pkg::*;

	localparam int COUNT_W = $clog2(MAX_AREAS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DECIDE,
		S_GATHER,
		S_COMMIT,
		S_PUT
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 out_valid_q;
	page_t                win_start_q;
	page_t                win_end_q;
	in_word_t             req_q;
	page_ext_t            cand_q;
	page_t                fsize_q;
	logic                 fowns_q;
	logic                 any_q;
	out_word_t            res_q;
	out_word_t            out_q;

	cell_ctl_t            ctl;
	logic [MAX_AREAS:0]   before_c;
	logic [MAX_AREAS-1:0] at_vec;
	page_ext_t            end_c   [MAX_AREAS];
	entry_t               ent_c   [MAX_AREAS];
	pick_t                pick_c  [MAX_AREAS];
	pick_t                pick_or;
	logic                 full;
	logic [PAGE_BITS+1:0] need;
	logic                 nospace;
	logic                 ins_ok;
	logic                 del_ok;
	out_word_t            res_d;
	logic                 out_take;
	logic                 put;
	logic                 commit_alloc;

	// slot row
	assign before_c[0] = 1'b0;

	for (genvar i = 0; i < MAX_AREAS; i++) begin : g_cell
		page_ext_t prev_end;
		entry_t    left_e;
		entry_t    right_e;
		logic      valid;

		assign valid = count_q > COUNT_W'(i);

		if (i == 0) begin : g_first
			assign prev_end = {1'b0, win_start_q};
			assign left_e   = '0;
		end else begin : g_mid
			assign prev_end = end_c[i-1];
			assign left_e   = ent_c[i-1];
		end

		if (i == MAX_AREAS - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = ent_c[i+1];
		end

		ffra_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.valid      (valid),
			.prev_end   (prev_end),
			.end_out    (end_c[i]),
			.left_entry (left_e),
			.right_entry(right_e),
			.entry      (ent_c[i]),
			.before_in  (before_c[i]),
			.before_out (before_c[i+1]),
			.slot       (at_vec[i]),
			.pick       (pick_c[i])
		);
	end

	// at most one slot is selected, so an or over the row picks its data
	always_comb begin
		pick_or = '0;
		for (int i = 0; i < MAX_AREAS; i++) begin
			pick_or = pick_or | pick_c[i];
		end
	end

	// commit decision
	assign full    = count_q == COUNT_W'(MAX_AREAS);
	assign need    = {1'b0, cand_q} + {2'b0, req_q.request_size};
	assign nospace = need > {2'b0, win_end_q};

	always_comb begin
		res_d  = '0;
		ins_ok = 1'b0;
		del_ok = 1'b0;
		case (req_q.kind)
			KIND_ALLOC: begin
				if (full) begin
					res_d.status = ST_FULL;
				end else if (nospace) begin
					res_d.status = ST_NOSPACE;
				end else begin
					res_d.status        = ST_OK;
					res_d.granted_start = cand_q[PAGE_BITS-1:0];
					ins_ok              = 1'b1;
				end
			end
			KIND_FREE: begin
				if (any_q) begin
					res_d.status     = ST_OK;
					res_d.freed_size = fsize_q;
					res_d.freed_owns = fowns_q;
					del_ok           = 1'b1;
				end else begin
					res_d.status = ST_NOTFOUND;
				end
			end
			default: res_d.status = ST_NOTFOUND;
		endcase
	end

	always_comb begin
		ctl.kind   = req_q.kind;
		ctl.size   = req_q.request_size;
		ctl.owns   = req_q.owner_flag;
		ctl.fstart = req_q.free_start;
		ctl.cand   = cand_q[PAGE_BITS-1:0];
		ctl.ins    = (state_q == S_COMMIT) && ins_ok;
		ctl.del    = (state_q == S_COMMIT) && del_ok;
	end

	assign out_take  = out_valid_q && !out_stall;
	assign put       = (state_q == S_PUT) && (!out_valid_q || out_take);
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign commit_alloc = (state_q == S_COMMIT) && (req_q.kind == KIND_ALLOC) && !full;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= '1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WINDOW_START: win_start_q <= cfg_data;
				CFG_WINDOW_END:   win_end_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// sequencer, entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL:   state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_GATHER;
				S_GATHER: state_q <= S_COMMIT;
				S_COMMIT: begin
					if (ins_ok) begin
						count_q <= count_q + 1'b1;
					end else if (del_ok) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (put) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request, gathered data and result words
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_word;
		end
		if (state_q == S_GATHER) begin
			cand_q  <= pick_or.cand;
			fsize_q <= pick_or.size;
			fowns_q <= pick_or.owns;
			any_q   <= before_c[MAX_AREAS];
		end
		if (state_q == S_COMMIT) begin
			res_q <= res_d;
		end
		if (put) begin
			out_q <= res_q;
		end
	end

	`FFRA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= COUNT_W'(MAX_AREAS), "count overflow")
	`FFRA_ASSERT_NOW(a_one_slot, state_q == S_COMMIT, $onehot0(at_vec), "several slots selected")
	`FFRA_ASSERT_NOW(a_alloc_slot, commit_alloc, any_q, "no slot for allocation below full")
	`FFRA_ASSERT_NXT(a_count_inc, ctl.ins, count_q == $past(count_q) + 1'b1, "count stuck")

endmodule
